/* hw/rtl/gpio_port_register_block_defines.svh */
// assertion macros for the gpio port register block
`ifndef GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH
`define GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define GPRB_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define GPRB_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/gprb_pkg.sv */
// shared types, constants and mask functions for the gpio port register block
package gprb_pkg;

    localparam int PIN_COUNT = 16;
    localparam int PORT_PINS = 16;
    localparam logic [PORT_PINS-1:0] PIN_MASK =
        PORT_PINS'((33'd1 << PIN_COUNT) - 33'd1);

    typedef enum logic {
        ACC_READ  = 1'b0,
        ACC_WRITE = 1'b1
    } t_access;

    typedef enum logic [3:0] {
        REG_MODE     = 4'd0,
        REG_TYPE     = 4'd1,
        REG_SPEED    = 4'd2,
        REG_PULL     = 4'd3,
        REG_INPUT    = 4'd4,
        REG_OUTPUT   = 4'd5,
        REG_SETRESET = 4'd6,
        REG_LOCK     = 4'd7,
        REG_AFL      = 4'd8,
        REG_AFH      = 4'd9
    } t_reg_sel;

    typedef enum logic [3:0] {
        LOCK_IDLE = 4'b0001,
        LOCK_ARM1 = 4'b0010,
        LOCK_ARM2 = 4'b0100,
        LOCK_ARM3 = 4'b1000
    } t_lock_step;

    // two bits per pin
    function automatic logic [2*PORT_PINS-1:0] spread2(input logic [PORT_PINS-1:0] pins);
        logic [2*PORT_PINS-1:0] m;
        m = '0;
        for (int i = 0; i < PORT_PINS; i++) begin
            m[2*i +: 2] = {2{pins[i]}};
        end
        return m;
    endfunction

    // four bits per pin
    function automatic logic [4*PORT_PINS-1:0] spread4(input logic [PORT_PINS-1:0] pins);
        logic [4*PORT_PINS-1:0] m;
        m = '0;
        for (int i = 0; i < PORT_PINS; i++) begin
            m[4*i +: 4] = {4{pins[i]}};
        end
        return m;
    endfunction

endpackage

/* hw/rtl/gprb_req_if.sv */
// request channel: one register access with the sampled pin levels
interface gprb_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  reg_sel;
    logic [31:0] write_data;
    logic [15:0] pin_levels;

    modport source (output valid, output mode, output reg_sel, output write_data,
                    output pin_levels, input ready);
    modport sink   (input valid, input mode, input reg_sel, input write_data,
                    input pin_levels, output ready);
endinterface

/* hw/rtl/gprb_rsp_if.sv */
// response channel: read data, output drive and lock status
interface gprb_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [15:0] pin_drive;
    logic        lock_active;

    modport source (output valid, output read_data, output pin_drive,
                    output lock_active, input ready);
    modport sink   (input valid, input read_data, input pin_drive,
                    input lock_active, output ready);
endinterface

/* hw/rtl/gpio_port_register_block.sv */
// gpio port register block top level: register file, lock sequencer, in/out stages
//
// Register port of a 16-pin gpio port. Each request transaction is one read or write
// of one of ten registers (mode, type, speed, pull, input, output, set/reset, lock,
// afl, afh) and carries the current pin levels; each one produces exactly one
// response transaction with the read data (zero on writes), the output data register
// after the access and the lock status. A request is taken every clock cycle unless a
// stalled response finds the input register full: it is captured in the input
// register, the register file is updated and the response computed from it, and the
// response lands in an output register; sustained throughput is one access per cycle
// while responses are not stalled, set by the single update of the register file
// per cycle. A stalled response holds the output register while one more request
// waits in the input register. Set/reset writes set bits 15:0 and clear bits 31:16
// of the output data, set winning. The lock key sequence is: write with bit 16 set,
// clear, set, same pin bits each time, then a read of the lock register; after that
// the configuration fields of the locked pins ignore writes until reset.
`include "gpio_port_register_block_defines.svh"

module gpio_port_register_block (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gprb_req_if.sink   i_req,
    gprb_rsp_if.source o_rsp
);
    import gprb_pkg::*;

    // input stage
    logic        r_in_valid;
    t_access     r_mode;
    t_reg_sel    r_reg_sel;
    logic [31:0] r_wdata;
    logic [PORT_PINS-1:0] r_levels;

    // register file
    logic [2*PORT_PINS-1:0] r_pin_modes, n_pin_modes;
    logic [PORT_PINS-1:0]   r_out_types, n_out_types;
    logic [2*PORT_PINS-1:0] r_out_speeds, n_out_speeds;
    logic [2*PORT_PINS-1:0] r_pull_modes, n_pull_modes;
    logic [31:0]            r_afl, n_afl;
    logic [31:0]            r_afh, n_afh;
    logic [PORT_PINS-1:0]   r_out_bits, n_out_bits;
    logic [PORT_PINS-1:0]   r_locked, n_locked;
    logic                   r_lock_key, n_lock_key;
    t_lock_step             r_lock_step, n_lock_step;

    // output stage
    logic        r_out_valid;
    logic [31:0] r_rdata, n_rdata;
    logic [PORT_PINS-1:0] r_pin_drive;
    logic        r_lock_active;

    logic                   advance;
    logic [PORT_PINS-1:0]   free_pins;
    logic [2*PORT_PINS-1:0] m2;
    logic [4*PORT_PINS-1:0] m4;
    logic [PORT_PINS-1:0]   wbits;
    logic                   wkey;
    logic                   same;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    assign free_pins = PIN_MASK & ~(r_lock_key ? r_locked : '0);
    assign m2        = spread2(free_pins);
    assign m4        = spread4(free_pins);
    assign wbits     = r_wdata[PORT_PINS-1:0];
    assign wkey      = r_wdata[16];
    assign same      = (wbits == r_locked);

    // read mux
    always_comb begin
        n_rdata = '0;
        if (r_mode == ACC_READ) begin
            unique case (r_reg_sel)
                REG_MODE:   n_rdata = r_pin_modes;
                REG_TYPE:   n_rdata = {16'd0, r_out_types};
                REG_SPEED:  n_rdata = r_out_speeds;
                REG_PULL:   n_rdata = r_pull_modes;
                REG_INPUT:  n_rdata = {16'd0, r_levels & PIN_MASK};
                REG_OUTPUT: n_rdata = {16'd0, r_out_bits};
                REG_LOCK:   n_rdata = {15'd0, r_lock_key, r_locked};
                REG_AFL:    n_rdata = r_afl;
                REG_AFH:    n_rdata = r_afh;
                default:    n_rdata = '0;
            endcase
        end
    end

    // register file update
    always_comb begin
        n_pin_modes  = r_pin_modes;
        n_out_types  = r_out_types;
        n_out_speeds = r_out_speeds;
        n_pull_modes = r_pull_modes;
        n_afl        = r_afl;
        n_afh        = r_afh;
        n_out_bits   = r_out_bits;
        n_locked     = r_locked;
        n_lock_key   = r_lock_key;
        n_lock_step  = r_lock_step;
        if (r_mode == ACC_WRITE) begin
            unique case (r_reg_sel)
                REG_MODE:     n_pin_modes  = (r_pin_modes & ~m2) | (r_wdata & m2);
                REG_TYPE:     n_out_types  = (r_out_types & ~free_pins)
                                             | (wbits & free_pins);
                REG_SPEED:    n_out_speeds = (r_out_speeds & ~m2) | (r_wdata & m2);
                REG_PULL:     n_pull_modes = (r_pull_modes & ~m2) | (r_wdata & m2);
                REG_OUTPUT:   n_out_bits   = wbits & PIN_MASK;
                REG_SETRESET: n_out_bits   = ((r_out_bits & ~r_wdata[31:16]) | wbits)
                                             & PIN_MASK;
                REG_LOCK: begin
                    if (!r_lock_key) begin
                        n_locked = wbits;
                        priority if (r_lock_step == LOCK_ARM1 && !wkey && same) begin
                            n_lock_step = LOCK_ARM2;
                        end else if (r_lock_step == LOCK_ARM2 && wkey && same) begin
                            n_lock_step = LOCK_ARM3;
                        end else begin
                            n_lock_step = wkey ? LOCK_ARM1 : LOCK_IDLE;
                        end
                    end
                end
                REG_AFL:      n_afl = (r_afl & ~m4[31:0]) | (r_wdata & m4[31:0]);
                REG_AFH:      n_afh = (r_afh & ~m4[63:32]) | (r_wdata & m4[63:32]);
                default: ;
            endcase
        end else if (r_reg_sel == REG_LOCK && !r_lock_key) begin
            // read closes the key sequence
            if (r_lock_step == LOCK_ARM3) begin
                n_lock_key = 1'b1;
            end
            n_lock_step = LOCK_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_mode    <= t_access'(i_req.mode);
            r_reg_sel <= t_reg_sel'(i_req.reg_sel);
            r_wdata   <= i_req.write_data;
            r_levels  <= i_req.pin_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_modes  <= '0;
            r_out_types  <= '0;
            r_out_speeds <= '0;
            r_pull_modes <= '0;
            r_afl        <= '0;
            r_afh        <= '0;
            r_out_bits   <= '0;
            r_locked     <= '0;
            r_lock_key   <= 1'b0;
            r_lock_step  <= LOCK_IDLE;
        end else if (advance) begin
            r_pin_modes  <= n_pin_modes;
            r_out_types  <= n_out_types;
            r_out_speeds <= n_out_speeds;
            r_pull_modes <= n_pull_modes;
            r_afl        <= n_afl;
            r_afh        <= n_afh;
            r_out_bits   <= n_out_bits;
            r_locked     <= n_locked;
            r_lock_key   <= n_lock_key;
            r_lock_step  <= n_lock_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rdata       <= n_rdata;
            r_pin_drive   <= n_out_bits;
            r_lock_active <= n_lock_key;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_rdata;
    assign o_rsp.pin_drive   = r_pin_drive;
    assign o_rsp.lock_active = r_lock_active;

    // lock key is sticky until reset
    `GPRB_ASSERT_NEXT(a_key_sticky, r_lock_key, r_lock_key, "lock key dropped")
    // sequencer parks once locked
    `GPRB_ASSERT_NOW(a_step_parked, r_lock_key, r_lock_step == LOCK_IDLE,
                     "lock sequencer active after lock")
    // key only comes from a lock read at the end of the sequence
    `GPRB_ASSERT_NOW(a_key_source, $rose(r_lock_key),
                     $past(advance) && $past(r_reg_sel) == REG_LOCK
                     && $past(r_mode) == ACC_READ && $past(r_lock_step) == LOCK_ARM3,
                     "lock key set without key sequence")
    // every processed access yields a response
    `GPRB_ASSERT_NEXT(a_resp_after_advance, advance, r_out_valid,
                      "processed access without response")
    // locked mode fields never change
    `GPRB_ASSERT_NOW(a_locked_modes, r_lock_key && $past(r_lock_key),
                     ((r_pin_modes ^ $past(r_pin_modes)) & spread2(r_locked)) == '0,
                     "locked pin mode changed")

endmodule

/* dv/gpio_port_register_block_test.sv */
// self-checking testbench for the gpio port register block with paced request and response traffic
`timescale 1ns / 100ps

module gpio_port_register_block_test;
    import gprb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 340;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS = 50;
    localparam logic [3:0] SEL_SPARE_LO = 4'd10;
    localparam logic [3:0] SEL_SPARE_HI = 4'd15;

    typedef struct packed {
        logic        mode;
        logic [3:0]  reg_sel;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } t_gpio_access;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic        lock_active;
    } t_gpio_rsp;

    logic i_clk;
    logic i_rst_n;

    gprb_req_if req_bus ();
    gprb_rsp_if rsp_bus ();

    gpio_port_register_block uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_gpio_access access_q[$];
    t_gpio_rsp    want_rsp_q[$];
    t_gpio_access drv_item;
    t_gpio_access seen_item;
    t_gpio_rsp    got_rsp;
    t_gpio_rsp    want_rsp;

    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    int  queued_items = 0;
    int  accepted_count = 0;
    int  checked_count = 0;
    int  err_count = 0;
    int  cycle_count = 0;
    int  n_reads = 0;
    int  n_writes = 0;
    int  n_lock_seqs = 0;
    bit  req_fire = 1'b0;

    // predicted register state
    logic [31:0] cfg_mode = '0;
    logic [15:0] cfg_otype = '0;
    logic [31:0] cfg_speed = '0;
    logic [31:0] cfg_pull = '0;
    logic [63:0] cfg_af = '0;
    logic [15:0] out_bits = '0;
    logic [15:0] lk_pins = '0;
    logic        lk_key = 1'b0;
    t_lock_step  lk_step = LOCK_IDLE;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [31:0] pin_field_mask2(input logic [15:0] pins);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < PORT_PINS; i++) begin
            if (pins[i]) m[2*i +: 2] = 2'b11;
        end
        return m;
    endfunction

    function automatic logic [63:0] pin_field_mask4(input logic [15:0] pins);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < PORT_PINS; i++) begin
            if (pins[i]) m[4*i +: 4] = 4'hF;
        end
        return m;
    endfunction

    function automatic t_gpio_rsp predict_access(input t_gpio_access a);
        t_gpio_rsp   r;
        logic [15:0] levels;
        logic [15:0] free_pins;
        logic [15:0] bits;
        logic [31:0] wd;
        logic [31:0] m2;
        logic [63:0] m4;
        logic        key_bit;
        logic        same;
        wd = a.write_data;
        levels = a.pin_levels & PIN_MASK;
        free_pins = PIN_MASK & ~(lk_key ? lk_pins : 16'h0);
        m2 = pin_field_mask2(free_pins);
        m4 = pin_field_mask4(free_pins);
        r.read_data = '0;
        if (a.mode != ACC_WRITE) begin
            n_reads++;
            case (a.reg_sel)
                REG_MODE:   r.read_data = cfg_mode;
                REG_TYPE:   r.read_data = {16'h0, cfg_otype};
                REG_SPEED:  r.read_data = cfg_speed;
                REG_PULL:   r.read_data = cfg_pull;
                REG_INPUT:  r.read_data = {16'h0, levels};
                REG_OUTPUT: r.read_data = {16'h0, out_bits};
                REG_LOCK:   r.read_data = {15'h0, lk_key, lk_pins};
                REG_AFL:    r.read_data = cfg_af[31:0];
                REG_AFH:    r.read_data = cfg_af[63:32];
                default:    r.read_data = '0;
            endcase
            if (a.reg_sel == REG_LOCK && !lk_key) begin
                if (lk_step == LOCK_ARM3) lk_key = 1'b1;
                lk_step = LOCK_IDLE;
            end
        end else begin
            n_writes++;
            case (a.reg_sel)
                REG_MODE:  cfg_mode = (cfg_mode & ~m2) | (wd & m2);
                REG_TYPE:  cfg_otype = (cfg_otype & ~free_pins) | (wd[15:0] & free_pins);
                REG_SPEED: cfg_speed = (cfg_speed & ~m2) | (wd & m2);
                REG_PULL:  cfg_pull = (cfg_pull & ~m2) | (wd & m2);
                REG_OUTPUT: out_bits = wd[15:0] & PIN_MASK;
                REG_SETRESET: out_bits = ((out_bits & ~wd[31:16]) | wd[15:0]) & PIN_MASK;
                REG_LOCK: begin
                    if (!lk_key) begin
                        bits = wd[15:0];
                        key_bit = wd[16];
                        same = (bits == lk_pins);
                        if (lk_step == LOCK_ARM1 && !key_bit && same) lk_step = LOCK_ARM2;
                        else if (lk_step == LOCK_ARM2 && key_bit && same) lk_step = LOCK_ARM3;
                        else lk_step = key_bit ? LOCK_ARM1 : LOCK_IDLE;
                        lk_pins = bits;
                    end
                end
                REG_AFL: cfg_af[31:0] = (cfg_af[31:0] & ~m4[31:0]) | (wd & m4[31:0]);
                REG_AFH: cfg_af[63:32] = (cfg_af[63:32] & ~m4[63:32]) | (wd & m4[63:32]);
                default: ;
            endcase
        end
        r.pin_drive = out_bits;
        r.lock_active = lk_key;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        end
        err_count++;
    endtask

    task automatic push_access(input logic mode, input logic [3:0] sel,
                               input logic [31:0] wd, input logic [15:0] pins);
        t_gpio_access a;
        a.mode = mode;
        a.reg_sel = sel;
        a.write_data = wd;
        a.pin_levels = pins;
        access_q.push_back(a);
        queued_items++;
    endtask

    task automatic push_random(input bit allow_lock);
        logic [3:0]  sel;
        logic [31:0] wd;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 6) sel = 4'($urandom_range(SEL_SPARE_LO, SEL_SPARE_HI));
        else sel = 4'($urandom_range(REG_MODE, REG_AFH));
        if (!allow_lock && sel == REG_LOCK) sel = REG_OUTPUT;
        pick = $urandom_range(99);
        if (pick < 10) wd = '0;
        else if (pick < 20) wd = '1;
        else wd = $urandom;
        push_access(1'($urandom_range(1)), sel, wd, 16'($urandom));
    endtask

    // key sequence with random pins, broken at brk unless brk is past the final read
    task automatic push_lock_seq(input bit complete);
        logic [15:0] bits;
        logic [15:0] flip;
        int          brk;
        bit          key_of_step;
        n_lock_seqs++;
        bits = 16'($urandom);
        if ($urandom_range(9) == 0) bits = '1;
        brk = complete ? 4 : $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
            repeat ($urandom_range(0, 2)) push_random(1'b0);
            key_of_step = (k != 1);
            if (k == brk) begin
                case ($urandom_range(2))
                    0: push_access(ACC_READ, REG_LOCK, $urandom, 16'($urandom));
                    1: push_access(ACC_WRITE, REG_LOCK,
                                   {15'($urandom), ~key_of_step, bits}, 16'($urandom));
                    default: begin
                        flip = 16'($urandom_range(1, 16'hFFFF));
                        push_access(ACC_WRITE, REG_LOCK,
                                    {15'($urandom), key_of_step, bits ^ flip},
                                    16'($urandom));
                    end
                endcase
                break;
            end
            if (k == 3) push_access(ACC_READ, REG_LOCK, $urandom, 16'($urandom));
            else push_access(ACC_WRITE, REG_LOCK, {15'($urandom), key_of_step, bits},
                             16'($urandom));
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (accepted_count != queued_items || want_rsp_q.size() != 0);
    endtask

    // request driver and response ready pacing
    always @(negedge i_clk) begin
        rsp_bus.ready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);
        if (i_rst_n && !(req_bus.valid && !req_fire)) begin
            if (access_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_item = access_q.pop_front();
                req_bus.valid <= 1'b1;
                req_bus.mode <= drv_item.mode;
                req_bus.reg_sel <= drv_item.reg_sel;
                req_bus.write_data <= drv_item.write_data;
                req_bus.pin_levels <= drv_item.pin_levels;
            end else begin
                req_bus.valid <= 1'b0;
                req_bus.mode <= 1'($urandom_range(1));
                req_bus.reg_sel <= 4'($urandom);
                req_bus.write_data <= $urandom;
                req_bus.pin_levels <= 16'($urandom);
            end
        end
    end

    // acceptance, prediction and response check
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, want_rsp_q.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            req_fire = i_rst_n && req_bus.valid && req_bus.ready;
            if (req_fire) begin
                seen_item.mode = req_bus.mode;
                seen_item.reg_sel = req_bus.reg_sel;
                seen_item.write_data = req_bus.write_data;
                seen_item.pin_levels = req_bus.pin_levels;
                want_rsp_q.push_back(predict_access(seen_item));
                accepted_count++;
            end
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
                got_rsp.read_data = rsp_bus.read_data;
                got_rsp.pin_drive = rsp_bus.pin_drive;
                got_rsp.lock_active = rsp_bus.lock_active;
                if (want_rsp_q.size() == 0) begin
                    report_mismatch("unexpected response read_data", got_rsp.read_data, '0);
                end else begin
                    want_rsp = want_rsp_q.pop_front();
                    checked_count++;
                    if (got_rsp.read_data !== want_rsp.read_data)
                        report_mismatch("read_data", got_rsp.read_data, want_rsp.read_data);
                    if (got_rsp.pin_drive !== want_rsp.pin_drive)
                        report_mismatch("pin_drive", {16'h0, got_rsp.pin_drive},
                                        {16'h0, want_rsp.pin_drive});
                    if (got_rsp.lock_active !== want_rsp.lock_active)
                        report_mismatch("lock_active", {31'h0, got_rsp.lock_active},
                                        {31'h0, want_rsp.lock_active});
                end
            end
        end
    end

    initial begin
        int  n0;
        bit  lock_pushed;
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.mode = ACC_READ;
        req_bus.reg_sel = REG_MODE;
        req_bus.write_data = '0;
        req_bus.pin_levels = '0;
        rsp_bus.ready = 1'b0;
        lock_pushed = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-ones into every register, read back, clears and spare selectors
        for (int r = REG_MODE; r <= REG_AFH; r++) begin
            push_access(ACC_WRITE, 4'(r), '1, '1);
            push_access(ACC_READ, 4'(r), '0, '1);
        end
        push_access(ACC_WRITE, REG_SETRESET, 32'hFFFF_0000, '0);
        push_access(ACC_READ, REG_OUTPUT, '1, '0);
        push_access(ACC_READ, REG_INPUT, '0, '0);
        push_access(ACC_WRITE, SEL_SPARE_HI, '1, '1);
        push_access(ACC_READ, SEL_SPARE_LO, '1, '1);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
                3: begin src_idle_pct = 18; snk_stall_pct = 18; end
                default: begin src_idle_pct = 0; snk_stall_pct = 0; end
            endcase
            n0 = queued_items;
            while (queued_items - n0 < PHASE_ITEMS) begin
                if (ph == 3 && !lock_pushed && queued_items - n0 >= PHASE_ITEMS / 2) begin
                    push_lock_seq(1'b1);
                    lock_pushed = 1'b1;
                end else if ($urandom_range(99) < 35) begin
                    push_lock_seq(lock_pushed && $urandom_range(1));
                end else begin
                    push_random(1'b1);
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (want_rsp_q.size() != 0)
            report_mismatch("responses never arrived", want_rsp_q.size(), '0);
        $display("%0d accesses (%0d reads, %0d writes) over five pacing phases, %0d checked",
                 accepted_count, n_reads, n_writes, checked_count);
        $display("%0d lock key sequences, lock engaged: %0d, locked pins %h",
                 n_lock_seqs, lk_key, lk_pins);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
